// ----- src/mdwt_pkg.sv -----
`timescale 1ns / 1ps
package mdwt_pkg;
	localparam int MAX_ITEMS = 65536;
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int CW = 17;
	localparam int TW = 31;
	localparam int SW = 32;

	typedef struct packed {
		logic          last;
		logic [TW-1:0] ts;
	} item_t;

	typedef struct packed {
		logic          overflow;
		logic          final_res;
		logic [SW-1:0] span;
		logic [CW-1:0] count;
		logic          valid;
	} res_t;
endpackage

// ----- src/mdwt_ram.sv -----
`timescale 1ns / 1ps
module mdwt_ram #(
	parameter int W = 8,
	parameter int D = 256
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);
	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end
endmodule

// ----- src/mdwt_front.sv -----
`timescale 1ns / 1ps
module mdwt_front import mdwt_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t in_item,
	output logic  q_valid,
	input  logic  q_pop,
	output item_t q_item
);
	item_t      buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       push, pop;

	assign in_ready = cnt_q != 2'd2;
	assign q_valid  = cnt_q != 2'd0;
	assign q_item   = buf_q[rp_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push)
			buf_q[wp_q] <= in_item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push)
				wp_q <= ~wp_q;
			if (pop)
				rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q != 2'd3)
		else $error("queue count out of range");
	a_ptr: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == 2'd0 || cnt_q == 2'd2) |-> wp_q == rp_q)
		else $error("queue pointers disagree with count");
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 2'd1 |-> wp_q != rp_q)
		else $error("queue pointers disagree with count");
endmodule

// ----- src/mdwt_core.sv -----
`timescale 1ns / 1ps
module mdwt_core import mdwt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic [CW-1:0] min_window,
	input  logic          q_valid,
	output logic          q_pop,
	input  item_t         q_item,
	output logic          res_valid,
	input  logic          res_ready,
	output res_t          res
);
	typedef enum logic [13:0] {
		S_IDLE = 14'b00000000000001,
		S_RDS  = 14'b00000000000010,
		S_WTS  = 14'b00000000000100,
		S_L0   = 14'b00000000001000,
		S_L1   = 14'b00000000010000,
		S_L2   = 14'b00000000100000,
		S_L3   = 14'b00000001000000,
		S_CMP  = 14'b00000010000000,
		S_PUSH = 14'b00000100000000,
		S_E0   = 14'b00001000000000,
		S_E1   = 14'b00010000000000,
		S_E2   = 14'b00100000000000,
		S_E3   = 14'b01000000000000,
		S_OUT  = 14'b10000000000000
	} state_t;

	state_t        state_q;
	logic          front_q;
	logic [CW-1:0] head_q, tail_q, cnt_q, best_n_q;
	logic [SW-1:0] best_w_q;
	logic          have_q, ovf_q, out_v_q;
	res_t          out_q;

	logic [AW-1:0] i_q, s_q, a_q, b_q, st_q;
	logic [TW-1:0] ts_q, tc_q, ta_q;
	logic          last_q;
	logic signed [50:0] p1_q, p2_q;
	logic signed [32:0] span_q;
	logic [CW-1:0] cntw_q;

	logic          t_we;
	logic [AW-1:0] t_raddr, d_raddr;
	logic [TW-1:0] t_rdata;
	logic [AW-1:0] d_rdata;
	logic          d_we;

	logic [CW-1:0] q_eff, nxt, s_full, depth;
	logic signed [17:0] m1a, m2a;
	logic signed [32:0] m1b, m2b;
	logic signed [51:0] diff;
	logic          pop_hit, start_ok, take;
	logic          out_load;

	assign q_eff    = (min_window == '0) ? CW'(1) : min_window;
	assign nxt      = cnt_q + CW'(1);
	assign s_full   = nxt - q_eff;
	assign depth    = tail_q - head_q;
	assign start_ok = !(ovf_q || cnt_q == CW'(MAX_ITEMS));
	assign q_pop    = state_q == S_IDLE;
	assign t_we     = state_q == S_IDLE && q_valid && start_ok;
	assign d_we     = state_q == S_PUSH;
	assign out_load = state_q == S_OUT && (!out_v_q || res_ready);

	mdwt_ram #(.W(TW), .D(MAX_ITEMS)) u_time (
		.clk(clk), .we(t_we), .waddr(cnt_q[AW-1:0]), .wdata(q_item.ts),
		.raddr(t_raddr), .rdata(t_rdata)
	);

	mdwt_ram #(.W(AW), .D(MAX_ITEMS)) u_hull (
		.clk(clk), .we(d_we), .waddr(tail_q[AW-1:0]), .wdata(s_q),
		.raddr(d_raddr), .rdata(d_rdata)
	);

	always_comb begin
		t_raddr = d_rdata;
		d_raddr = head_q[AW-1:0];
		case (state_q)
			S_RDS: t_raddr = s_q;
			S_L0:  d_raddr = front_q ? head_q[AW-1:0] : AW'(tail_q - CW'(2));
			S_L1:  d_raddr = front_q ? AW'(head_q + CW'(1)) : AW'(tail_q - CW'(1));
			default: begin
				t_raddr = d_rdata;
				d_raddr = head_q[AW-1:0];
			end
		endcase
	end

	always_comb begin
		if (state_q == S_E2) begin
			m1a = $signed({2'b00, i_q}) - $signed({2'b00, st_q}) + 18'sd1;
			m1b = $signed({1'b0, best_w_q});
			m2a = $signed({1'b0, best_n_q});
			m2b = $signed({2'b00, ts_q}) - $signed({2'b00, t_rdata}) + 33'sd1;
		end else if (front_q) begin
			m1a = $signed({2'b00, i_q}) - $signed({2'b00, b_q}) + 18'sd1;
			m1b = $signed({2'b00, ts_q}) - $signed({2'b00, ta_q}) + 33'sd1;
			m2a = $signed({2'b00, i_q}) - $signed({2'b00, a_q}) + 18'sd1;
			m2b = $signed({2'b00, ts_q}) - $signed({2'b00, t_rdata}) + 33'sd1;
		end else begin
			m1a = $signed({2'b00, b_q}) - $signed({2'b00, a_q});
			m1b = $signed({2'b00, tc_q}) - $signed({2'b00, ta_q});
			m2a = $signed({2'b00, s_q}) - $signed({2'b00, a_q});
			m2b = $signed({2'b00, t_rdata}) - $signed({2'b00, ta_q});
		end
	end

	assign diff    = $signed({p1_q[50], p1_q}) - $signed({p2_q[50], p2_q});
	assign pop_hit = front_q ? (!diff[51] && diff != '0) : !diff[51];
	assign take    = (span_q > 33'sd0) && (!have_q || p1_q > p2_q);

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				ts_q   <= q_item.ts;
				last_q <= q_item.last;
				i_q    <= cnt_q[AW-1:0];
				s_q    <= s_full[AW-1:0];
			end
			S_WTS: tc_q <= t_rdata;
			S_L1:  a_q  <= d_rdata;
			S_L2: begin
				b_q  <= d_rdata;
				ta_q <= t_rdata;
			end
			S_L3: begin
				p1_q <= m1a * m1b;
				p2_q <= m2a * m2b;
			end
			S_E1: st_q <= d_rdata;
			S_E2: begin
				p1_q   <= m1a * m1b;
				p2_q   <= m2a * m2b;
				span_q <= m2b;
				cntw_q <= m1a[CW-1:0];
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			front_q  <= 1'b0;
			head_q   <= '0;
			tail_q   <= '0;
			cnt_q    <= '0;
			best_n_q <= '0;
			best_w_q <= '0;
			have_q   <= 1'b0;
			ovf_q    <= 1'b0;
			out_v_q  <= 1'b0;
			out_q    <= '0;
		end else begin
			if (out_v_q && res_ready && !out_load)
				out_v_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (!start_ok) begin
							ovf_q   <= 1'b1;
							state_q <= S_OUT;
						end else begin
							cnt_q   <= nxt;
							state_q <= (nxt >= q_eff) ? S_RDS : S_OUT;
						end
					end
				end
				S_RDS: state_q <= S_WTS;
				S_WTS: begin
					front_q <= 1'b0;
					state_q <= S_L0;
				end
				S_L0: begin
					if (depth > CW'(1))
						state_q <= S_L1;
					else
						state_q <= front_q ? S_E0 : S_PUSH;
				end
				S_L1: state_q <= S_L2;
				S_L2: state_q <= S_L3;
				S_L3: state_q <= S_CMP;
				S_CMP: begin
					if (pop_hit) begin
						if (front_q)
							head_q <= head_q + CW'(1);
						else
							tail_q <= tail_q - CW'(1);
						state_q <= S_L0;
					end else begin
						state_q <= front_q ? S_E0 : S_PUSH;
					end
				end
				S_PUSH: begin
					tail_q  <= tail_q + CW'(1);
					front_q <= 1'b1;
					state_q <= S_L0;
				end
				S_E0: state_q <= S_E1;
				S_E1: state_q <= S_E2;
				S_E2: state_q <= S_E3;
				S_E3: begin
					if (take) begin
						have_q   <= 1'b1;
						best_n_q <= cntw_q;
						best_w_q <= span_q[SW-1:0];
					end
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						out_v_q         <= 1'b1;
						out_q.valid     <= have_q;
						out_q.count     <= have_q ? best_n_q : '0;
						out_q.span      <= have_q ? best_w_q : '0;
						out_q.final_res <= last_q;
						out_q.overflow  <= ovf_q;
						if (last_q) begin
							head_q   <= '0;
							tail_q   <= '0;
							cnt_q    <= '0;
							best_n_q <= '0;
							best_w_q <= '0;
							have_q   <= 1'b0;
							ovf_q    <= 1'b0;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign res_valid = out_v_q;
	assign res       = out_q;

	a_onehot: assert property (@(posedge clk) disable iff (!arst_n) $onehot(state_q))
		else $error("state not one-hot");
	a_order: assert property (@(posedge clk) disable iff (!arst_n) tail_q >= head_q)
		else $error("deque head passed tail");
	a_cnt: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= CW'(MAX_ITEMS))
		else $error("item count beyond storage");
	a_best: assert property (@(posedge clk) disable iff (!arst_n)
		!have_q |-> (best_n_q == '0 && best_w_q == '0))
		else $error("best window held without valid flag");
endmodule

// ----- src/max_density_window_tracker_top.sv -----
`timescale 1ns / 1ps
// Each item runs a hull walk paced by the single read port of the timestamp and hull RAMs,
// which the walk uses one entry at a time: one deque test per pop, plus the test ending a walk;
// items that form no window skip the walk. A stalled output adds its wait.
// One item in work at a time; a 2-beat input queue and the output register decouple the sides.
// Reset (arst_n low, asynchronous) empties the run state and sets min_window to 1; no RAM clearing.
module max_density_window_tracker_top import mdwt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [CW-1:0] cfg_data,
	input  logic          s_axis_tvalid,
	output logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,  // timestamp[30:0]
	input  logic          s_axis_tlast,  // last_item
	output logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	output logic [55:0]   m_axis_tdata,  // best_valid, best_count, best_span, overflow
	output logic          m_axis_tlast   // final_res
);
	logic [CW-1:0] min_window_q;
	logic          q_valid, q_pop;
	item_t         in_item, q_item;
	res_t          res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			min_window_q <= CW'(1);
		else if (cfg_valid)
			min_window_q <= cfg_data;
	end

	assign in_item.ts   = s_axis_tdata[TW-1:0];
	assign in_item.last = s_axis_tlast;

	mdwt_front u_front (
		.clk(clk), .arst_n(arst_n),
		.in_valid(s_axis_tvalid), .in_ready(s_axis_tready), .in_item(in_item),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item)
	);

	mdwt_core u_core (
		.clk(clk), .arst_n(arst_n), .min_window(min_window_q),
		.q_valid(q_valid), .q_pop(q_pop), .q_item(q_item),
		.res_valid(m_axis_tvalid), .res_ready(m_axis_tready), .res(res)
	);

	assign m_axis_tdata = {5'b0, res.overflow, res.span, res.count, res.valid};
	assign m_axis_tlast = res.final_res;
endmodule

// ----- bench/density_checker.sv -----
`timescale 1ns / 1ps
module density_checker import mdwt_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_valid,
	input  logic          cfg_ready,
	input  logic [CW-1:0] cfg_data,
	input  logic          s_axis_tvalid,
	input  logic          s_axis_tready,
	input  logic [31:0]   s_axis_tdata,  // timestamp[30:0]
	input  logic          s_axis_tlast,  // last_item
	input  logic          m_axis_tvalid,
	input  logic          m_axis_tready,
	input  logic [55:0]   m_axis_tdata,  // best_valid, best_count, best_span, overflow
	input  logic          m_axis_tlast,  // final_res
	output int            fails,
	output int            pending
);
	typedef struct packed {
		logic          overflow;
		logic          final_res;
		logic [SW-1:0] span;
		logic [CW-1:0] count;
		logic          valid;
	} density_t;

	logic [TW-1:0] stamps [MAX_ITEMS];
	logic [AW:0]   hull [MAX_ITEMS];
	logic [CW-1:0] win_min;
	int unsigned   head, tail, n_items, top_count;
	longint unsigned top_span;
	bit            have_top, ovf;
	density_t      densest_q [$];

	function automatic bit pop_back(int unsigned a, int unsigned b, int unsigned c);
		longint ta, tb, tc;
		ta = stamps[a];
		tb = stamps[b];
		tc = stamps[c];
		return (longint'(b) - longint'(a)) * (tc - ta) - (longint'(c) - longint'(a)) * (tb - ta) >= 0;
	endfunction

	function automatic bit pop_front(int unsigned a, int unsigned b, int unsigned c);
		longint ta, tb, tc;
		ta = stamps[a];
		tb = stamps[b];
		tc = stamps[c];
		return (longint'(c) - longint'(b) + 1) * (tc - ta + 1) -
			(longint'(c) - longint'(a) + 1) * (tc - tb + 1) > 0;
	endfunction

	function automatic void clear_run();
		head = 0;
		tail = 0;
		n_items = 0;
		top_count = 0;
		top_span = 0;
		have_top = 0;
		ovf = 0;
	endfunction

	function automatic density_t track_density(logic [TW-1:0] ts, logic last);
		int unsigned q, i, s, st;
		longint unsigned cnt;
		longint span;
		density_t r;
		q = (win_min == 0) ? 1 : win_min;
		if (!ovf && n_items >= MAX_ITEMS)
			ovf = 1;
		if (!ovf) begin
			i = n_items;
			stamps[i] = ts;
			n_items = i + 1;
			if (i + 1 >= q) begin
				s = i + 1 - q;
				while (tail - head > 1 && pop_back(hull[tail-2], hull[tail-1], s))
					tail--;
				hull[tail] = s[AW:0];
				tail++;
				while (tail - head > 1 && pop_front(hull[head], hull[head+1], i))
					head++;
				st = hull[head];
				cnt = i - st + 1;
				span = longint'(stamps[i]) - longint'(stamps[st]) + 1;
				if (span > 0 && (!have_top || cnt * top_span > longint'(top_count) * span)) begin
					have_top = 1;
					top_count = 32'(cnt);
					top_span = span;
				end
			end
		end
		r.valid = have_top;
		r.count = have_top ? top_count[CW-1:0] : '0;
		r.span = have_top ? top_span[SW-1:0] : '0;
		r.final_res = last;
		r.overflow = ovf;
		if (last)
			clear_run();
		return r;
	endfunction

	assign pending = densest_q.size();

	always @(posedge clk or negedge arst_n) begin
		density_t e, a;
		if (!arst_n) begin
			win_min = 1;
			clear_run();
			fails = 0;
			densest_q.delete();
		end else begin
			if (cfg_valid && cfg_ready)
				win_min = cfg_data;
			if (s_axis_tvalid && s_axis_tready)
				densest_q.push_back(track_density(s_axis_tdata[TW-1:0], s_axis_tlast));
			if (m_axis_tvalid && m_axis_tready) begin
				a.valid = m_axis_tdata[0];
				a.count = m_axis_tdata[17:1];
				a.span = m_axis_tdata[49:18];
				a.overflow = m_axis_tdata[50];
				a.final_res = m_axis_tlast;
				if (densest_q.size() == 0) begin
					fails++;
					if (fails <= 10)
						$display("unexpected result beat: %h last %b", m_axis_tdata, m_axis_tlast);
				end else begin
					e = densest_q.pop_front();
					if (e.valid !== a.valid || e.count !== a.count || e.span !== a.span ||
							e.final_res !== a.final_res || e.overflow !== a.overflow ||
							m_axis_tdata[55:51] !== 0) begin
						fails++;
						if (fails <= 10)
							$display("mismatch: exp v%b c%0d s%0d l%b o%b, got v%b c%0d s%0d l%b o%b pad %h",
								e.valid, e.count, e.span, e.final_res, e.overflow, a.valid,
								a.count, a.span, a.final_res, a.overflow, m_axis_tdata[55:51]);
					end
				end
			end
		end
	end
endmodule

// ----- bench/max_density_window_tracker_top_tb.sv -----
`timescale 1ns / 1ps
module max_density_window_tracker_top_tb import mdwt_pkg::*; ();
	localparam int WATCHDOG = 50000;

	logic          clk = 0;
	logic          arst_n = 0;
	logic          cfg_valid = 0;
	logic          cfg_ready;
	logic [CW-1:0] cfg_data = 0;
	logic          s_axis_tvalid = 0;
	logic          s_axis_tready;
	logic [31:0]   s_axis_tdata = 0;
	logic          s_axis_tlast = 0;
	logic          m_axis_tvalid;
	logic          m_axis_tready = 0;
	logic [55:0]   m_axis_tdata;
	logic          m_axis_tlast;
	int            fails, pending, quiet;
	int            send_idle = 0, recv_stall = 0;
	logic [TW-1:0] stamp;

	always begin
		#10 clk = 1;
		#10 clk = 0;
	end

	max_density_window_tracker_top uut (.*);
	density_checker chk (.*);

	always @(posedge clk)
		m_axis_tready <= ($urandom_range(99) >= recv_stall);

	always @(posedge clk) begin
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
				(cfg_valid && cfg_ready))
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= WATCHDOG) begin
			$display("FAIL max_density_window_tracker_top");
			$finish;
		end
	end

	task automatic drain();
		while (pending != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic set_window(logic [CW-1:0] w);
		drain();
		cfg_valid <= 1;
		cfg_data <= w;
		do begin
			@(negedge clk);
		end while (!cfg_ready);
		@(posedge clk);
		cfg_valid <= 0;
	endtask

	// beat stays up through back-to-back items; gaps only when idling
	task automatic send(logic [TW-1:0] ts, logic last);
		if ($urandom_range(99) < send_idle) begin
			s_axis_tvalid <= 0;
			repeat ($urandom_range(8, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1;
		s_axis_tdata <= {1'b0, ts};
		s_axis_tlast <= last;
		do begin
			@(negedge clk);
		end while (!s_axis_tready);
		@(posedge clk);
	endtask

	task automatic stop_send();
		s_axis_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic random_run(int len);
		int k;
		for (k = 0; k < len; k++) begin
			case ($urandom_range(9))
				0: stamp = stamp - TW'($urandom_range(3));
				1: stamp = stamp + TW'($urandom);
				2, 3: stamp = stamp + TW'($urandom_range(5000));
				default: stamp = stamp + TW'($urandom_range(4, 1));
			endcase
			send(stamp, k == len - 1);
		end
	endtask

	initial begin
		int ph, n, len;
		repeat (8) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed
		set_window(0);
		send(31'd0, 0);
		send(31'h7fffffff, 1);
		send(31'h7fffffff, 0);
		send(31'h7fffffff, 0);
		send(31'd5, 0);
		send(31'd6, 1);
		stop_send();
		set_window(17'h1ffff);
		send(31'd1, 0);
		send(31'd2, 1);
		stop_send();
		set_window(3);
		send(31'd10, 0);
		send(31'd11, 1);
		send(31'h2aaaaaaa, 0);
		send(31'h55555555, 0);
		send(31'h55555556, 0);
		send(31'h55555557, 0);
		send(31'h55555600, 0);
		send(31'h55555601, 1);
		stop_send();

		// random
		for (ph = 0; ph < 4; ph++) begin
			send_idle = (ph == 1) ? 85 : (ph == 3) ? 34 : 0;
			recv_stall = (ph == 2) ? 85 : (ph == 3) ? 34 : 0;
			n = 0;
			while (n < 125) begin
				stop_send();
				set_window(CW'($urandom_range(3) == 0 ? 1 : $urandom_range(8, 1)));
				stamp = TW'($urandom);
				len = $urandom_range(25, 1);
				n += len;
				random_run(len);
				stop_send();
				if ($urandom_range(3) == 0)
					drain();
			end
		end

		drain();
		if (fails == 0)
			$display("PASS max_density_window_tracker_top");
		else
			$display("FAIL max_density_window_tracker_top");
		$finish;
	end
endmodule
